// File: design/skrb_pkg.sv
// Shared constants, types and helpers of the split keyboard report builder.
`timescale 1ns / 1ps

package skrb_pkg;

    localparam int DEVICE_COUNT     = 4;
    localparam int SLOTS_PER_DEVICE = 6;
    localparam int POSITION_COUNT   = 64;
    localparam int SHOWN_SLOTS      = 6;

    localparam int DEV_W  = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
    localparam int POS_W  = (POSITION_COUNT > 1) ? $clog2(POSITION_COUNT) : 1;
    localparam int SLOT_W = (SLOTS_PER_DEVICE > 1) ? $clog2(SLOTS_PER_DEVICE) : 1;

    localparam logic [7:0] ID_BASE_RESET = 8'd16;

    typedef enum logic [2:0] {
        CMD_PRESS,
        CMD_RELEASE,
        CMD_MOD_SET,
        CMD_MOD_CLEAR,
        CMD_CLEAR_DEV,
        CMD_CLEAR_ALL,
        CMD_RESEND_ALL,
        CMD_RESERVED
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK,
        ST_INVALID,
        ST_FULL
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } t_state;

    typedef logic [SLOTS_PER_DEVICE-1:0][7:0] t_row;

    typedef struct packed {
        logic accept;
        logic exec;
        logic emit;
        logic next_dev;
    } t_ctrl_cmd;

    typedef struct packed {
        logic multi;
        logic cnt_last;
        logic out_busy;
    } t_dp_status;

    function automatic logic [2:0] dev_of_position(input logic [7:0] pos);
        logic [2:0] d;
        case (pos)
            8'd6, 8'd7:   d = 3'd1;
            8'd18, 8'd19: d = 3'd2;
            8'd30, 8'd31: d = 3'd3;
            default:      d = 3'd0;
        endcase
        return d;
    endfunction

endpackage

// File: design/split_keyboard_report_builder_core.sv
// Top level of the split keyboard report builder: controller plus datapath.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   cmd, position, key_code, device, mod_mask
//  out      output     o_out_valid / i_out_ready report fields, status, last
//  cfg      input      i_cfg_valid / o_cfg_ready report identifier base (8 bits)
//
// An item passes accept, position-store read and update, and emit into the output
// register to its single result; clear all and resend all emit one result per
// device. The next item is taken once the last result is in the output register,
// even while it waits to be taken. Synchronous active-low reset empties all
// reports and the position store (valid bits). A stalled output holds the
// controller in emit.
`timescale 1ns / 1ps

module split_keyboard_report_builder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_position,
    input  logic [7:0] i_key_code,
    input  logic [2:0] i_device,
    input  logic [7:0] i_mod_mask,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_report_valid,
    output logic [7:0] o_rpt_id,
    output logic [1:0] o_report_device,
    output logic [7:0] o_modifiers,
    output logic [7:0] o_slot0,
    output logic [7:0] o_slot1,
    output logic [7:0] o_slot2,
    output logic [7:0] o_slot3,
    output logic [7:0] o_slot4,
    output logic [7:0] o_slot5,
    output logic [1:0] o_status,
    output logic       o_last
);
    import skrb_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    assign o_cfg_ready = i_rst_n;

    skrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    skrb_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctrl_cmd),
        .o_status        (dp_status),
        .i_cmd_code      (i_cmd),
        .i_position      (i_position),
        .i_key_code      (i_key_code),
        .i_device        (i_device),
        .i_mod_mask      (i_mod_mask),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_report_valid  (o_report_valid),
        .o_rpt_id        (o_rpt_id),
        .o_report_device (o_report_device),
        .o_modifiers     (o_modifiers),
        .o_slot0         (o_slot0),
        .o_slot1         (o_slot1),
        .o_slot2         (o_slot2),
        .o_slot3         (o_slot3),
        .o_slot4         (o_slot4),
        .o_slot5         (o_slot5),
        .o_last_status   (o_status),
        .o_last          (o_last)
    );

endmodule

// File: design/skrb_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module skrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/skrb_ctrl.sv
// Controller state machine: accept, execute, emit results.
`timescale 1ns / 1ps

module skrb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  skrb_pkg::t_dp_status i_status,
    output skrb_pkg::t_ctrl_cmd  o_cmd
);
    import skrb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.multi && !i_status.cnt_last) begin
                        o_cmd.next_dev = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/skrb_datapath.sv
// Datapath: report state, position store, slot search and shift, output register.
`timescale 1ns / 1ps

module skrb_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  skrb_pkg::t_ctrl_cmd  i_cmd,
    output skrb_pkg::t_dp_status o_status,
    input  logic [2:0]           i_cmd_code,
    input  logic [7:0]           i_position,
    input  logic [7:0]           i_key_code,
    input  logic [2:0]           i_device,
    input  logic [7:0]           i_mod_mask,
    input  logic                 i_cfg_valid,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_report_valid,
    output logic [7:0]           o_rpt_id,
    output logic [1:0]           o_report_device,
    output logic [7:0]           o_modifiers,
    output logic [7:0]           o_slot0,
    output logic [7:0]           o_slot1,
    output logic [7:0]           o_slot2,
    output logic [7:0]           o_slot3,
    output logic [7:0]           o_slot4,
    output logic [7:0]           o_slot5,
    output logic [1:0]           o_last_status,
    output logic                 o_last
);
    import skrb_pkg::*;

    // latched item
    t_cmd       r_cmd;
    logic [7:0] r_pos;
    logic [7:0] r_key;
    logic [2:0] r_dev;
    logic [7:0] r_mask;

    // report state
    t_row                    r_slots [DEVICE_COUNT];
    logic [7:0]              r_mods [DEVICE_COUNT];
    logic [POSITION_COUNT-1:0] r_pk_valid;
    logic                    r_pk_hit;
    logic [7:0]              r_id_base;

    // outcome of the executed item
    logic                    r_rep_kind;
    t_status                 r_rep_status;
    logic [DEV_W-1:0]        r_rep_dev;
    logic [DEV_W-1:0]        r_cnt;

    // output register
    logic                    r_out_valid;
    logic                    r_out_report_valid;
    logic [7:0]              r_out_id;
    logic [1:0]              r_out_dev;
    logic [7:0]              r_out_mods;
    logic [SHOWN_SLOTS-1:0][7:0] r_out_slots;
    t_status                 r_out_status;
    logic                    r_out_last;

    logic [7:0]       pk_rd_data;
    logic [2:0]       map_dev;
    logic             pos_ok;
    logic             map_ok;
    logic             dev_ok;
    logic [DEV_W-1:0] sel_dev;
    t_row             cur_row;
    t_row             shifted;
    t_row             press_row;
    t_row             rel_row;
    logic [7:0]       stored_key;
    logic [7:0]       search_key;
    logic             found;
    logic [SLOT_W-1:0] idx;
    logic [7:0]       cur_mod;

    logic             rep_kind;
    t_status          rep_status;
    logic             row_we;
    t_row             new_row;
    logic             mod_we;
    logic [7:0]       new_mod;
    logic             pk_wr;
    logic             pk_clr;
    logic             clear_all;

    logic             multi;
    logic             cnt_last;
    logic [DEV_W-1:0] emit_dev;
    logic             emit_report;
    logic [(SHOWN_SLOTS+SLOTS_PER_DEVICE)*8-1:0] padded;

    skrb_ram #(
        .WIDTH (8),
        .DEPTH (POSITION_COUNT)
    ) u_pk_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.exec && pk_wr),
        .i_wr_addr (r_pos[POS_W-1:0]),
        .i_wr_data (r_key),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (i_position[POS_W-1:0]),
        .o_rd_data (pk_rd_data)
    );

    always_comb begin
        map_dev = dev_of_position(r_pos);
        pos_ok  = {1'b0, r_pos} < 9'(POSITION_COUNT);
        map_ok  = {1'b0, map_dev} < 4'(DEVICE_COUNT);
        dev_ok  = {1'b0, r_dev} < 4'(DEVICE_COUNT);
        if (r_cmd == CMD_PRESS || r_cmd == CMD_RELEASE) begin
            sel_dev = map_dev[DEV_W-1:0];
        end else begin
            sel_dev = r_dev[DEV_W-1:0];
        end
        cur_row    = r_slots[sel_dev];
        cur_mod    = r_mods[sel_dev];
        stored_key = r_pk_hit ? pk_rd_data : 8'd0;
        search_key = (r_cmd == CMD_PRESS) ? r_key : stored_key;

        // press stops at the key or the first empty slot, release at the key
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < SLOTS_PER_DEVICE; i++) begin
            if (!found && (cur_row[i] == search_key ||
                           (r_cmd == CMD_PRESS && cur_row[i] == 8'd0))) begin
                found = 1'b1;
                idx   = SLOT_W'(i);
            end
        end

        press_row      = cur_row;
        press_row[idx] = r_key;
        shifted        = cur_row >> 8;
        for (int j = 0; j < SLOTS_PER_DEVICE; j++) begin
            rel_row[j] = (SLOT_W'(j) < idx) ? cur_row[j] : shifted[j];
        end

        rep_kind   = 1'b0;
        rep_status = ST_OK;
        row_we     = 1'b0;
        new_row    = cur_row;
        mod_we     = 1'b0;
        new_mod    = cur_mod;
        pk_wr      = 1'b0;
        pk_clr     = 1'b0;
        clear_all  = 1'b0;

        case (r_cmd)
            CMD_PRESS: begin
                if (!pos_ok) begin
                    rep_status = ST_INVALID;
                end else begin
                    pk_wr = 1'b1;
                    if (!map_ok) begin
                        rep_status = ST_INVALID;
                    end else if (!found) begin
                        rep_status = ST_FULL;
                    end else if (cur_row[idx] != r_key) begin
                        rep_kind = 1'b1;
                        row_we   = 1'b1;
                        new_row  = press_row;
                    end
                end
            end
            CMD_RELEASE: begin
                if (!pos_ok) begin
                    rep_status = ST_INVALID;
                end else if (stored_key != 8'd0) begin
                    pk_clr = 1'b1;
                    if (!map_ok) begin
                        rep_status = ST_INVALID;
                    end else if (found) begin
                        rep_kind = 1'b1;
                        row_we   = 1'b1;
                        new_row  = rel_row;
                    end
                end
            end
            CMD_MOD_SET, CMD_MOD_CLEAR: begin
                if (!dev_ok) begin
                    rep_status = ST_INVALID;
                end else begin
                    rep_kind = 1'b1;
                    mod_we   = 1'b1;
                    new_mod  = (r_cmd == CMD_MOD_SET) ? (cur_mod | r_mask)
                                                      : (cur_mod & ~r_mask);
                end
            end
            CMD_CLEAR_DEV: begin
                if (!dev_ok) begin
                    rep_status = ST_INVALID;
                end else begin
                    rep_kind = 1'b1;
                    row_we   = 1'b1;
                    new_row  = '0;
                end
            end
            CMD_CLEAR_ALL: begin
                clear_all = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign multi    = (r_cmd == CMD_CLEAR_ALL) || (r_cmd == CMD_RESEND_ALL);
    assign cnt_last = (r_cnt == DEV_W'(DEVICE_COUNT - 1));

    assign o_status.multi    = multi;
    assign o_status.cnt_last = cnt_last;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < DEVICE_COUNT; d++) begin
                r_slots[d] <= '0;
                r_mods[d]  <= '0;
            end
            r_pk_valid  <= '0;
            r_id_base   <= ID_BASE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_id_base <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                if (row_we) begin
                    r_slots[sel_dev] <= new_row;
                end
                if (clear_all) begin
                    for (int d = 0; d < DEVICE_COUNT; d++) begin
                        r_slots[d] <= '0;
                    end
                end
                if (mod_we) begin
                    r_mods[sel_dev] <= new_mod;
                end
                if (pk_wr) begin
                    r_pk_valid[r_pos[POS_W-1:0]] <= 1'b1;
                end
                if (pk_clr) begin
                    r_pk_valid[r_pos[POS_W-1:0]] <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd    <= t_cmd'(i_cmd_code);
            r_pos    <= i_position;
            r_key    <= i_key_code;
            r_dev    <= i_device;
            r_mask   <= i_mod_mask;
            r_pk_hit <= r_pk_valid[i_position[POS_W-1:0]];
            r_cnt    <= '0;
        end else if (i_cmd.next_dev) begin
            r_cnt <= r_cnt + DEV_W'(1);
        end
        if (i_cmd.exec) begin
            r_rep_kind   <= rep_kind;
            r_rep_status <= rep_status;
            r_rep_dev    <= sel_dev;
        end
    end

    always_comb begin
        emit_dev    = multi ? r_cnt : r_rep_dev;
        emit_report = multi || r_rep_kind;
        padded      = {{(SHOWN_SLOTS*8){1'b0}}, r_slots[emit_dev]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_report_valid <= emit_report;
            r_out_id           <= emit_report ? (r_id_base + 8'(emit_dev)) : 8'd0;
            r_out_dev          <= emit_report ? 2'(emit_dev) : 2'd0;
            r_out_mods         <= emit_report ? r_mods[emit_dev] : 8'd0;
            for (int s = 0; s < SHOWN_SLOTS; s++) begin
                r_out_slots[s] <= emit_report ? padded[s*8 +: 8] : 8'd0;
            end
            r_out_status       <= emit_report ? ST_OK : r_rep_status;
            r_out_last         <= multi ? cnt_last : 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_report_valid  = r_out_report_valid;
    assign o_rpt_id        = r_out_id;
    assign o_report_device = r_out_dev;
    assign o_modifiers     = r_out_mods;
    assign o_slot0         = r_out_slots[0];
    assign o_slot1         = r_out_slots[1];
    assign o_slot2         = r_out_slots[2];
    assign o_slot3         = r_out_slots[3];
    assign o_slot4         = r_out_slots[4];
    assign o_slot5         = r_out_slots[5];
    assign o_last_status   = r_out_status;
    assign o_last          = r_out_last;

endmodule

// File: design/skrb_checker.sv
// Port-level assertions for the split keyboard report builder, bound to the top.
`timescale 1ns / 1ps

module skrb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_report_valid,
    input logic [7:0] o_rpt_id,
    input logic [1:0] o_report_device,
    input logic [7:0] o_modifiers,
    input logic [7:0] o_slot0,
    input logic [7:0] o_slot5,
    input logic [1:0] o_status,
    input logic       o_last
);
    import skrb_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rpt_id) && $stable(o_last))
        else $error("stalled result changed");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_report_valid |->
            o_rpt_id == 8'd0 && o_report_device == 2'd0 && o_modifiers == 8'd0 &&
            o_slot0 == 8'd0 && o_slot5 == 8'd0 && o_last)
        else $error("result without report is not clean");

    a_report_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_report_valid |-> o_status == ST_OK)
        else $error("report carries a status");

    a_busy_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("item taken before last result");

endmodule

bind split_keyboard_report_builder_core skrb_checker u_skrb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_report_valid  (o_report_valid),
    .o_rpt_id        (o_rpt_id),
    .o_report_device (o_report_device),
    .o_modifiers     (o_modifiers),
    .o_slot0         (o_slot0),
    .o_slot5         (o_slot5),
    .o_status        (o_status),
    .o_last          (o_last)
);
